// ===== src/sbcb_pkg.sv =====
package sbcb_pkg;

    // Default number of screen rows covered by the clip map.
    localparam int MAX_LINES_DEF = 1024;

    // The clip map is stored as words of MAP_W row bits.
    localparam int MAP_W  = 16;
    localparam int MAP_WB = $clog2(MAP_W);

    // Configuration register indexes (byte address divided by four).
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_LEFT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_TOP   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_COLS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_LINES = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_COLS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_LINES = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE   = 3'd6;
    localparam int PADDR_W = REG_IDX_W + 2;

    // Blend mode codes.
    localparam logic [1:0] MODE_OPAQUE   = 2'd0;
    localparam logic [1:0] MODE_EMBEDDED = 2'd1;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_PIXEL     = 2'd0,
        OP_ADD_ROWS  = 2'd1,
        OP_CLEAR_MAP = 2'd2,
        OP_NO_CLIP   = 2'd3
    } t_opcode;

    // Clip map sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILL_RD,
        ST_FILL_WR
    } t_state;

    // Input beat.
    typedef struct packed {
        t_opcode            opcode;
        logic [31:0]        sprite_pixel;
        logic [31:0]        dest_pixel;
        logic signed [15:0] clip_first_row;
        logic [14:0]        clip_row_count;
    } t_in_item;

    // Output beat.
    typedef struct packed {
        logic        write_enable;
        logic [11:0] dest_col;
        logic [9:0]  dest_row;
        logic [31:0] out_pixel;
        logic        sprite_done;
    } t_out_item;

endpackage

// ===== src/sbcb_clip_ram.sv =====
module sbcb_clip_ram #(
    parameter int DEPTH = sbcb_pkg::MAX_LINES_DEF / sbcb_pkg::MAP_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = sbcb_pkg::MAP_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sbcb_blend.sv =====
module sbcb_blend (
    input  logic [31:0] i_top,
    input  logic [31:0] i_bot,
    output logic [31:0] o_pix
);

    logic [7:0]  alpha;
    logic [7:0]  inv_alpha;
    logic [31:0] mixed;

    assign alpha     = i_top[31:24];
    assign inv_alpha = alpha ^ 8'hFF;

    // One lane per channel: top + round((bot * (255 - a)) / 255).
    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [15:0] prod;
        logic [15:0] rnd;
        logic [23:0] scaled;

        assign prod   = 16'(i_bot[8*g +: 8]) * 16'(inv_alpha);
        assign rnd    = prod + 16'h0080;
        assign scaled = {rnd, 8'h00} + {8'h00, rnd};
        assign mixed[8*g +: 8] = i_top[8*g +: 8] + scaled[23:16];
    end

    // Transparent backdrop or opaque sprite passes the sprite; clear sprite keeps the backdrop.
    always_comb begin
        if (i_bot[31:24] == 8'h00 || alpha == 8'hFF) begin
            o_pix = i_top;
        end else if (alpha == 8'h00) begin
            o_pix = i_bot;
        end else begin
            o_pix = mixed;
        end
    end

endmodule

// ===== src/sprite_blit_clip_blend_top.sv =====
// Sprite blitter: takes sprite pixels in raster order with the backdrop pixel at each
// destination, and returns one beat per input beat: the screen position and the opaque or
// alpha-blended value when the pixel lands on screen and its row passes the clip map, or a
// beat with write_enable low otherwise. Pixel beats and disable-clipping beats are taken one
// per cycle while the output is not stalled and pass through the first-stage and output
// registers. The clip map sits in a single-port memory of MAX_LINES/16 words of 16 row bits;
// a clear-map beat sweeps it when clipping is on, blocking input, and an add-rows beat does a
// read-modify-write of every 16-row word it touches, after that same sweep when clipping
// was off. Clipping is off after reset and the map is not cleared until it turns on, so there
// is no clearing pass at reset. Configure through the APB port only while the block is idle.
module sprite_blit_clip_blend_top #(
    parameter int MAX_LINES = sbcb_pkg::MAX_LINES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  sbcb_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sbcb_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbcb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sbcb_pkg::*;

    localparam int DEPTH = (MAX_LINES + MAP_W - 1) / MAP_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(MAX_LINES);
    localparam logic [17:0] MAXL18 = 18'(MAX_LINES);
    localparam logic [15:0] MAXL16 = 16'(MAX_LINES);
    localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

    // Configuration registers.
    logic [15:0] r_sprite_left;
    logic [15:0] r_sprite_top;
    logic [11:0] r_sprite_cols;
    logic [11:0] r_sprite_lines;
    logic [12:0] r_screen_cols;
    logic [10:0] r_screen_lines;
    logic [1:0]  r_blend_mode;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_left  <= 16'd0;
            r_sprite_top   <= 16'd0;
            r_sprite_cols  <= 12'd1;
            r_sprite_lines <= 12'd1;
            r_screen_cols  <= 13'd640;
            r_screen_lines <= 11'd480;
            r_blend_mode   <= MODE_OPAQUE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SPRITE_LEFT:  r_sprite_left  <= pwdata[15:0];
                REG_SPRITE_TOP:   r_sprite_top   <= pwdata[15:0];
                REG_SPRITE_COLS:  r_sprite_cols  <= pwdata[11:0];
                REG_SPRITE_LINES: r_sprite_lines <= pwdata[11:0];
                REG_SCREEN_COLS:  r_screen_cols  <= pwdata[12:0];
                REG_SCREEN_LINES: r_screen_lines <= pwdata[10:0];
                REG_BLEND_MODE:   r_blend_mode   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (cfg_idx)
            REG_SPRITE_LEFT:  prdata = {16'd0, r_sprite_left};
            REG_SPRITE_TOP:   prdata = {16'd0, r_sprite_top};
            REG_SPRITE_COLS:  prdata = {20'd0, r_sprite_cols};
            REG_SPRITE_LINES: prdata = {20'd0, r_sprite_lines};
            REG_SCREEN_COLS:  prdata = {19'd0, r_screen_cols};
            REG_SCREEN_LINES: prdata = {21'd0, r_screen_lines};
            REG_BLEND_MODE:   prdata = {30'd0, r_blend_mode};
            default:          prdata = 32'd0;
        endcase
    end

    // Control state.
    t_state       r_state;
    t_state       n_state;
    logic [11:0]  r_col;
    logic [11:0]  r_row;
    logic         r_clip_active;
    logic [AW-1:0] r_word;
    logic [AW-1:0] r_lo_word;
    logic [AW-1:0] r_last_word;
    logic [MAP_WB-1:0] r_lo_bit;
    logic [MAP_WB-1:0] r_last_bit;
    logic         r_fill_go;

    // First pipeline stage.
    logic              r_s1_valid;
    logic              r_s1_cand;
    logic              r_s1_chk;
    logic              r_s1_inmap;
    logic [MAP_WB-1:0] r_s1_bit;
    logic [11:0]       r_s1_col;
    logic [9:0]        r_s1_row;
    logic              r_s1_embed;
    logic              r_s1_done;
    logic [31:0]       r_s1_spix;
    logic [31:0]       r_s1_dpix;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    logic s1_adv;
    logic acc;
    logic acc_pix;
    logic acc_add;
    logic busy;

    // Memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [MAP_W-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [MAP_W-1:0] ram_rdata;

    // Handshake.
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = busy || (r_s1_valid && !s1_adv);
    assign acc        = i_in_valid && !o_in_stall;
    assign acc_pix    = acc && (i_in_data.opcode == OP_PIXEL);
    assign acc_add    = acc && (i_in_data.opcode == OP_ADD_ROWS);

    // Screen position of the current sprite pixel.
    logic [16:0] sx;
    logic [16:0] sy;
    logic        on_screen;
    logic        sy_in_map;
    logic        last_col;
    logic        last_row;
    logic [AW-1:0] pix_word;

    assign sx = {r_sprite_left[15], r_sprite_left} + {5'd0, r_col};
    assign sy = {r_sprite_top[15], r_sprite_top} + {5'd0, r_row};
    assign on_screen = !sx[16] && (sx[15:0] < {3'd0, r_screen_cols}) &&
                       !sy[16] && (sy[15:0] < {5'd0, r_screen_lines});
    assign sy_in_map = !sy[16] && (sy[15:0] < MAXL16);
    assign last_col  = ({1'b0, r_col} + 13'd1) >= {1'b0, r_sprite_cols};
    assign last_row  = ({1'b0, r_row} + 13'd1) >= {1'b0, r_sprite_lines};
    assign pix_word  = AW'(sy[15:0] >> MAP_WB);

    // Row range of an add-rows beat, clipped to the screen and the map.
    logic [17:0] first18;
    logic [17:0] end18;
    logic [17:0] lim18;
    logic [17:0] lo18;
    logic [17:0] hi18;
    logic [17:0] last18;
    logic        range_ok;
    logic [LW-1:0] lo_row;
    logic [LW-1:0] last_row_idx;

    assign first18 = {{2{i_in_data.clip_first_row[15]}}, i_in_data.clip_first_row};
    assign end18   = first18 + {3'd0, i_in_data.clip_row_count};
    assign lim18   = ({7'd0, r_screen_lines} < MAXL18) ? {7'd0, r_screen_lines} : MAXL18;
    assign lo18    = first18[17] ? 18'd0 : first18;
    assign hi18    = ($signed(end18) < $signed(lim18)) ? end18 : lim18;
    assign last18  = hi18 - 18'd1;
    assign range_ok     = $signed(hi18) > $signed(lo18);
    assign lo_row       = LW'(lo18);
    assign last_row_idx = LW'(last18);

    // Bits of the current word that the fill range covers.
    logic [MAP_W-1:0] fill_mask;
    logic [MAP_W-1:0] mask_lo;
    logic [MAP_W-1:0] mask_hi;

    always_comb begin
        mask_lo   = (r_word == r_lo_word) ? ({MAP_W{1'b1}} << r_lo_bit) : {MAP_W{1'b1}};
        mask_hi   = (r_word == r_last_word) ? ({MAP_W{1'b1}} >> (~r_last_bit))
                                            : {MAP_W{1'b1}};
        fill_mask = mask_lo & mask_hi;
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_add) begin
                    if (!r_clip_active) begin
                        n_state = ST_CLEAR;
                    end else if (range_ok) begin
                        n_state = ST_FILL_RD;
                    end
                end else if (acc && i_in_data.opcode == OP_CLEAR_MAP && r_clip_active) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (r_word == LAST_WORD) begin
                    n_state = r_fill_go ? ST_FILL_RD : ST_IDLE;
                end
            end
            ST_FILL_RD: begin
                n_state = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                n_state = (r_word == r_last_word) ? ST_IDLE : ST_FILL_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory port and input hold.
    always_comb begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_word;
        unique case (r_state)
            ST_IDLE: begin
                busy      = 1'b0;
                ram_re    = acc_pix;
                ram_raddr = pix_word;
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_FILL_RD: begin
                ram_re = 1'b1;
            end
            ST_FILL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | fill_mask;
            end
            default: ;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_clip_active <= 1'b0;
            r_word        <= '0;
            r_fill_go     <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_add) begin
                        r_clip_active <= 1'b1;
                        r_fill_go     <= range_ok;
                        r_word        <= r_clip_active ? AW'(lo_row >> MAP_WB) : '0;
                    end else if (acc && i_in_data.opcode == OP_CLEAR_MAP) begin
                        r_fill_go <= 1'b0;
                        r_word    <= '0;
                    end else if (acc && i_in_data.opcode == OP_NO_CLIP) begin
                        r_clip_active <= 1'b0;
                    end
                end
                ST_CLEAR: begin
                    r_word <= (r_word == LAST_WORD) ? r_lo_word : r_word + AW'(1);
                end
                ST_FILL_WR: begin
                    r_word <= r_word + AW'(1);
                end
                default: ;
            endcase
        end
    end

    // Fill range bounds, captured with the add-rows beat.
    always_ff @(posedge i_clk) begin
        if (acc_add) begin
            r_lo_word   <= AW'(lo_row >> MAP_WB);
            r_last_word <= AW'(last_row_idx >> MAP_WB);
            r_lo_bit    <= lo_row[MAP_WB-1:0];
            r_last_bit  <= last_row_idx[MAP_WB-1:0];
        end
    end

    // Sprite column and row counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 12'd0;
            r_row <= 12'd0;
        end else if (acc_pix) begin
            if (last_col) begin
                r_col <= 12'd0;
                r_row <= last_row ? 12'd0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + 12'd1;
            end
        end
    end

    // First stage: position checks and operands; the map word is read alongside.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cand  <= acc_pix && on_screen && !r_blend_mode[1];
            r_s1_chk   <= r_clip_active;
            r_s1_inmap <= sy_in_map;
            r_s1_bit   <= sy[MAP_WB-1:0];
            r_s1_col   <= sx[11:0];
            r_s1_row   <= sy[9:0];
            r_s1_embed <= (r_blend_mode == MODE_EMBEDDED);
            r_s1_done  <= acc_pix && last_col && last_row;
            r_s1_spix  <= i_in_data.sprite_pixel;
            r_s1_dpix  <= i_in_data.dest_pixel;
        end
    end

    sbcb_clip_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (MAP_W)
    ) u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic [31:0] blended;

    sbcb_blend u_blend (
        .i_top (r_s1_spix),
        .i_bot (r_s1_dpix),
        .o_pix (blended)
    );

    // Second stage: clip decision and pixel value.
    logic      s1_we;
    t_out_item n_out;

    always_comb begin
        s1_we = r_s1_cand && (!r_s1_chk || (r_s1_inmap && ram_rdata[r_s1_bit]));
        n_out = '0;
        n_out.sprite_done = r_s1_done;
        if (s1_we) begin
            n_out.write_enable = 1'b1;
            n_out.dest_col     = r_s1_col;
            n_out.dest_row     = r_s1_row;
            n_out.out_pixel    = r_s1_embed ? blended : (r_s1_spix | 32'hFF00_0000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // No beat is taken while the map is being cleared or filled.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input beat taken while clip map sequencer busy");

    // The map is written only by the sequencer.
    a_map_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_FILL_WR))
        else $error("clip map written outside clear or fill");

    // The last pixel of the sprite returns both counters to zero.
    a_counter_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_pix && last_col && last_row) |=> (r_col == 12'd0 && r_row == 12'd0))
        else $error("sprite counters did not wrap after last pixel");

    // Adding clip rows always leaves clipping enabled.
    a_add_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_add |=> r_clip_active)
        else $error("clipping not enabled after add-rows beat");

endmodule
